// File: hdl/ldtl_pkg.sv
// Shared types, constants and the device-ID text for the loop display talker/listener.
package ldtl_pkg;

  localparam int IdCharsDefault = 7;

  typedef enum logic [1:0] {
    ROLE_IDLE        = 2'd0,
    ROLE_LISTEN      = 2'd1,
    ROLE_TALK_ADDR   = 2'd2,
    ROLE_TALK_ACTIVE = 2'd3
  } role_t;

  typedef enum logic [1:0] {
    MODE_DEVICE      = 2'd0,
    MODE_SCOPE       = 2'd1,
    MODE_LISTEN_ONLY = 2'd2,
    MODE_DEVICE_ALT  = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    CFG_MONITOR_MODE  = 1'b0,
    CFG_DEVICE_STATUS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    role_t      role;
    logic [4:0] loop_address;
    logic       address_assigned;
    logic [2:0] id_index;
  } state_t;

  typedef struct packed {
    logic        clear_display;
    logic [7:0]  show_char;
    logic        show_char_valid;
    logic [10:0] frame_out;
  } result_t;

  localparam logic [10:0] FRAME_EOT    = 11'h540;
  localparam logic [7:0]  ACCESSORY_ID = 8'd48;
  localparam logic [4:0]  AUTO_ADDRESS = 5'd3;

  localparam logic [2:0]  CLASS_CMD = 3'd4;
  localparam logic [2:0]  CLASS_RDY = 3'd5;

  // command groups (payload bits 7..5)
  localparam logic [2:0]  GRP_UCG  = 3'd0;
  localparam logic [2:0]  GRP_LAD  = 3'd1;
  localparam logic [2:0]  GRP_TAD  = 3'd2;
  localparam logic [2:0]  GRP_MISC = 3'd4;

  localparam logic [7:0]  CMD_SDC = 8'd4;
  localparam logic [7:0]  CMD_DCL = 8'd20;
  localparam logic [4:0]  LOW_UNL = 5'd31;
  localparam logic [4:0]  LOW_IFC = 5'd16;
  localparam logic [4:0]  LOW_AAU = 5'd26;

  localparam logic [7:0]  RDY_NRD   = 8'd66;
  localparam logic [7:0]  RDY_SST   = 8'd97;
  localparam logic [7:0]  RDY_SDI   = 8'd98;
  localparam logic [7:0]  RDY_SAI   = 8'd99;
  localparam logic [7:0]  RDY_LIMIT = 8'd127;
  localparam logic [7:0]  AAD_LIMIT = 8'h9e;

  localparam logic [7:0]  CHAR_DOT = 8'h2e;
  localparam logic [7:0]  CHAR_LF  = 8'd10;
  localparam logic [7:0]  CHAR_CR  = 8'd13;
  localparam logic [7:0]  CHAR_SP  = 8'd32;

  function automatic logic [7:0] id_char(input logic [2:0] i, input logic [2:0] n);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h44; // D
      3'd1:    c = 8'h49; // I
      3'd2:    c = 8'h53; // S
      3'd3:    c = 8'h50; // P
      3'd4:    c = 8'h4c; // L
      3'd5:    c = 8'h41; // A
      3'd6:    c = 8'h59; // Y
      default: c = 8'h00;
    endcase
    if (i >= n) c = 8'h00;
    return c;
  endfunction

endpackage

// File: hdl/ldtl_frame_logic.sv
// Per-frame decode: role/address state update, reply frame and display actions.
module ldtl_frame_logic #(
  parameter int ID_CHARS = ldtl_pkg::IdCharsDefault
) (
  input  ldtl_pkg::mode_t   mode,
  input  logic [7:0]        device_status,
  input  ldtl_pkg::state_t  state_cur,
  input  logic [10:0]       frame,
  output ldtl_pkg::result_t result,
  output ldtl_pkg::state_t  state_next
);

  localparam logic [2:0] NumChars = 3'(ID_CHARS);

  logic [7:0] n;
  logic [4:0] low;
  logic [2:0] grp;
  logic [2:0] idx;
  logic [7:0] c;

  assign n   = frame[7:0];
  assign low = n[4:0];
  assign grp = n[7:5];

  always_comb begin
    result            = '0;
    result.frame_out  = frame;
    state_next        = state_cur;
    idx               = state_cur.id_index;
    c                 = ldtl_pkg::id_char(idx, NumChars);

    case (mode)
      ldtl_pkg::MODE_SCOPE: begin
      end
      ldtl_pkg::MODE_LISTEN_ONLY: begin
        if (!frame[10]) begin
          result.show_char_valid = 1'b1;
          if (n == ldtl_pkg::CHAR_LF || n == ldtl_pkg::CHAR_CR ||
              (n >= ldtl_pkg::CHAR_SP && n <= ldtl_pkg::RDY_LIMIT)) begin
            result.show_char = n;
          end else begin
            result.show_char = ldtl_pkg::CHAR_DOT;
          end
        end
      end
      default: begin
        if (!frame[10]) begin
          if (state_cur.role[0]) begin
            if (state_cur.role[1]) begin
              if (idx != 3'd0) begin
                result.frame_out = {3'b000, c};
                idx = (c == 8'h00) ? 3'd0 : idx + 3'd1;
              end
              if (idx == 3'd0) begin
                result.frame_out = ldtl_pkg::FRAME_EOT;
                state_next.role  = ldtl_pkg::ROLE_TALK_ADDR;
              end
              state_next.id_index = idx;
            end else begin
              result.show_char_valid = 1'b1;
              result.show_char       = n;
            end
          end
        end else if (frame[10:8] == ldtl_pkg::CLASS_CMD) begin
          case (grp)
            ldtl_pkg::GRP_UCG: begin
              if (n == ldtl_pkg::CMD_SDC) begin
                result.clear_display = state_cur.role[0];
              end else if (n == ldtl_pkg::CMD_DCL) begin
                result.clear_display = 1'b1;
              end
            end
            ldtl_pkg::GRP_LAD: begin
              if (low == ldtl_pkg::LOW_UNL) begin
                if (!state_cur.role[1]) state_next.role = ldtl_pkg::ROLE_IDLE;
              end else if (low == state_cur.loop_address) begin
                state_next.role = ldtl_pkg::ROLE_LISTEN;
              end
            end
            ldtl_pkg::GRP_TAD: begin
              if (low == state_cur.loop_address) begin
                state_next.role = ldtl_pkg::ROLE_TALK_ADDR;
              end else if (state_cur.role[1]) begin
                state_next.role = ldtl_pkg::ROLE_IDLE;
              end
            end
            ldtl_pkg::GRP_MISC: begin
              if (low == ldtl_pkg::LOW_IFC) begin
                state_next.role = ldtl_pkg::ROLE_IDLE;
              end else if (low == ldtl_pkg::LOW_AAU) begin
                state_next.loop_address     = ldtl_pkg::AUTO_ADDRESS;
                state_next.address_assigned = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end else if (frame[10:8] == ldtl_pkg::CLASS_RDY) begin
          if (n <= ldtl_pkg::RDY_LIMIT) begin
            if (state_cur.role[1]) begin
              case (n)
                ldtl_pkg::RDY_NRD: state_next.id_index = 3'd0;
                ldtl_pkg::RDY_SST: begin
                  result.frame_out = {3'b000, device_status};
                  state_next.role  = ldtl_pkg::ROLE_TALK_ACTIVE;
                end
                ldtl_pkg::RDY_SDI: begin
                  result.frame_out    = {3'b000, ldtl_pkg::id_char(3'd0, NumChars)};
                  state_next.id_index = 3'd1;
                  state_next.role     = ldtl_pkg::ROLE_TALK_ACTIVE;
                end
                ldtl_pkg::RDY_SAI: begin
                  result.frame_out = {3'b000, ldtl_pkg::ACCESSORY_ID};
                  state_next.role  = ldtl_pkg::ROLE_TALK_ACTIVE;
                end
                default: begin
                end
              endcase
            end
          end else if (n < ldtl_pkg::AAD_LIMIT) begin
            if (!state_cur.address_assigned) begin
              state_next.loop_address     = low;
              state_next.address_assigned = 1'b1;
              result.frame_out            = frame + 11'd1;
            end
          end
        end
      end
    endcase
  end

endmodule

// File: hdl/loop_display_talker_listener.sv
// Top level: config registers, input register, frame logic, result register.
// A word is taken into the input register, then moves on to the result register.
// One word per cycle unless the output stalls; the role/address state
// updates as a word moves from the input register to the result register.
// Reset (rst, synchronous): both registers empty, role idle, address 0,
// unassigned, ID index 0, monitor_mode and device_status 0.
module loop_display_talker_listener #(
  parameter int ID_CHARS = ldtl_pkg::IdCharsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [10:0] frame_in, [15:11] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [10:0] frame_out, [11] show_char_valid,
                                     // [19:12] show_char, [20] clear_display, [23:21] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  ldtl_pkg::mode_t   monitor_mode;
  logic [7:0]        device_status;
  ldtl_pkg::state_t  state;
  ldtl_pkg::state_t  state_next;
  ldtl_pkg::result_t result_next;
  ldtl_pkg::result_t result;
  logic              in_valid;
  logic [10:0]       in_frame;
  logic              out_valid;
  logic              advance;

  assign cfg_ready     = 1'b1;
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, result};

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_mode  <= ldtl_pkg::MODE_DEVICE;
      device_status <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ldtl_pkg::CFG_MONITOR_MODE:  monitor_mode  <= ldtl_pkg::mode_t'(cfg_data[1:0]);
        ldtl_pkg::CFG_DEVICE_STATUS: device_status <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_frame <= s_axis_tdata[10:0];
    end
  end

  ldtl_frame_logic #(
    .ID_CHARS(ID_CHARS)
  ) u_frame_logic (
    .mode         (monitor_mode),
    .device_status(device_status),
    .state_cur    (state),
    .frame        (in_frame),
    .result       (result_next),
    .state_next   (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      state     <= '0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        state <= state_next;
      end
    end
    if (advance && in_valid) begin
      result <= result_next;
    end
  end

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && out_valid && !m_axis_tready))
    else $error("input stalled while a stage is free");

  a_show_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[11]) |-> (m_axis_tdata[19:12] == 8'h00))
    else $error("show_char nonzero without show_char_valid");

  a_assigned_range: assert property (@(posedge clk) disable iff (rst)
    state.address_assigned |-> (state.loop_address <= 5'd29))
    else $error("assigned loop address out of range");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !(advance && in_valid) |=> $stable(state))
    else $error("state changed with no word moving");

endmodule

// File: test/loop_display_talker_listener_test.sv
`timescale 1ns / 1ps
// Testbench for loop_display_talker_listener: directed and random loop traffic checked word by word.
module loop_display_talker_listener_test;

  localparam int ID_LEN = ldtl_pkg::IdCharsDefault;
  localparam logic [7:0] ID_TEXT [0:6] = '{8'h44, 8'h49, 8'h53, 8'h50, 8'h4c, 8'h41, 8'h59};
  localparam logic [7:0] LAST_PRINTABLE = 8'd127;
  localparam logic [2:0] CLASS_DATA = 3'd0;
  localparam logic [2:0] CLASS_SKIP = 3'd6;
  localparam logic [7:0] AAD_BASE = 8'h80;
  localparam int AAD_SPAN = 29;
  localparam int PHASE_ITEMS = 100;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [10:0] frame_in
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [10:0] frame_out, [11] show_char_valid, [19:12] show_char,
                               // [20] clear_display
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  ldtl_pkg::result_t pending_responses[$];
  int      fail_count = 0;
  int      sent_items = 0;
  bit      src_quiet = 1'b0;
  bit      snk_quiet = 1'b0;

  // device model state
  ldtl_pkg::role_t dev_role = ldtl_pkg::ROLE_IDLE;
  logic [4:0]      dev_addr = '0;
  logic            dev_assigned = 1'b0;
  logic [2:0]      dev_id_pos = '0;
  ldtl_pkg::mode_t dev_mode = ldtl_pkg::MODE_DEVICE;
  logic [7:0]      dev_status = '0;

  loop_display_talker_listener u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("loop_display_talker_listener_test: FAIL");
    $finish;
  end

  function automatic logic [7:0] id_letter(input logic [2:0] pos);
    if (pos >= ID_LEN) return 8'h00;
    return ID_TEXT[pos];
  endfunction

  function automatic logic [10:0] cmd_frame(input logic [2:0] grp, input logic [4:0] low);
    return {ldtl_pkg::CLASS_CMD, grp, low};
  endfunction

  function automatic logic [10:0] rdy_frame(input logic [7:0] pay);
    return {ldtl_pkg::CLASS_RDY, pay};
  endfunction

  function automatic logic [10:0] data_frame(input logic [7:0] pay);
    return {CLASS_DATA, pay};
  endfunction

  function automatic logic [10:0] any_data_frame();
    return 11'($urandom_range(0, 1023));
  endfunction

  // Expected output word for one loop frame; advances the device model.
  function automatic ldtl_pkg::result_t loop_response(input logic [10:0] f);
    ldtl_pkg::result_t r;
    logic [7:0] pay;
    logic [4:0] low;
    logic [7:0] c;
    pay = f[7:0];
    low = pay[4:0];
    r = '0;
    r.frame_out = f;
    if (dev_mode == ldtl_pkg::MODE_SCOPE) begin
    end else if (dev_mode == ldtl_pkg::MODE_LISTEN_ONLY) begin
      if (!f[10]) begin
        r.show_char_valid = 1'b1;
        if (pay == ldtl_pkg::CHAR_LF || pay == ldtl_pkg::CHAR_CR ||
            (pay >= ldtl_pkg::CHAR_SP && pay <= LAST_PRINTABLE))
          r.show_char = pay;
        else
          r.show_char = ldtl_pkg::CHAR_DOT;
      end
    end else if (!f[10]) begin
      if (dev_role == ldtl_pkg::ROLE_LISTEN) begin
        r.show_char_valid = 1'b1;
        r.show_char = pay;
      end else if (dev_role == ldtl_pkg::ROLE_TALK_ACTIVE) begin
        if (dev_id_pos != 0) begin
          c = id_letter(dev_id_pos);
          r.frame_out = {3'b000, c};
          if (c == 8'h00) dev_id_pos = '0;
          else dev_id_pos = dev_id_pos + 3'd1;
        end
        if (dev_id_pos == 0) begin
          r.frame_out = ldtl_pkg::FRAME_EOT;
          dev_role = ldtl_pkg::ROLE_TALK_ADDR;
        end
      end
    end else if (f[10:8] == ldtl_pkg::CLASS_CMD) begin
      case (pay[7:5])
        ldtl_pkg::GRP_UCG: begin
          if (pay == ldtl_pkg::CMD_SDC) r.clear_display = dev_role[0];
          else if (pay == ldtl_pkg::CMD_DCL) r.clear_display = 1'b1;
        end
        ldtl_pkg::GRP_LAD: begin
          if (low == ldtl_pkg::LOW_UNL) begin
            if (!dev_role[1]) dev_role = ldtl_pkg::ROLE_IDLE;
          end else if (low == dev_addr) begin
            dev_role = ldtl_pkg::ROLE_LISTEN;
          end
        end
        ldtl_pkg::GRP_TAD: begin
          if (low == dev_addr) dev_role = ldtl_pkg::ROLE_TALK_ADDR;
          else if (dev_role[1]) dev_role = ldtl_pkg::ROLE_IDLE;
        end
        ldtl_pkg::GRP_MISC: begin
          if (low == ldtl_pkg::LOW_IFC) begin
            dev_role = ldtl_pkg::ROLE_IDLE;
          end else if (low == ldtl_pkg::LOW_AAU) begin
            dev_addr = ldtl_pkg::AUTO_ADDRESS;
            dev_assigned = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (f[10:8] == ldtl_pkg::CLASS_RDY) begin
      if (pay <= ldtl_pkg::RDY_LIMIT) begin
        if (dev_role[1]) begin
          if (pay == ldtl_pkg::RDY_NRD) begin
            dev_id_pos = '0;
          end else if (pay == ldtl_pkg::RDY_SST) begin
            r.frame_out = {3'b000, dev_status};
            dev_role = ldtl_pkg::ROLE_TALK_ACTIVE;
          end else if (pay == ldtl_pkg::RDY_SDI) begin
            r.frame_out = {3'b000, id_letter(3'd0)};
            dev_id_pos = 3'd1;
            dev_role = ldtl_pkg::ROLE_TALK_ACTIVE;
          end else if (pay == ldtl_pkg::RDY_SAI) begin
            r.frame_out = {3'b000, ldtl_pkg::ACCESSORY_ID};
            dev_role = ldtl_pkg::ROLE_TALK_ACTIVE;
          end
        end
      end else if (pay < ldtl_pkg::AAD_LIMIT) begin
        if (!dev_assigned) begin
          dev_addr = low;
          dev_assigned = 1'b1;
          r.frame_out = f + 11'd1;
        end
      end
    end
    return r;
  endfunction

  task automatic send_frame(input logic [10:0] f);
    int gap;
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b00000, f};
    do @(posedge clk); while (!s_axis_tready);
    pending_responses.push_back(loop_response(f));
    sent_items++;
  endtask

  // Stop sending and wait until every expected word has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input ldtl_pkg::mode_t mode, input logic [7:0] status);
    cfg_valid <= 1'b1;
    cfg_index <= ldtl_pkg::CFG_MONITOR_MODE;
    cfg_data <= {6'b000000, mode};
    do @(posedge clk); while (!cfg_ready);
    dev_mode = mode;
    cfg_index <= ldtl_pkg::CFG_DEVICE_STATUS;
    cfg_data <= status;
    do @(posedge clk); while (!cfg_ready);
    dev_status = status;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [10:0] want, input logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin : result_checker
    int                stall;
    ldtl_pkg::result_t got;
    ldtl_pkg::result_t want;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) snk_quiet = !snk_quiet;
      stall = snk_quiet ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got = ldtl_pkg::result_t'(m_axis_tdata[20:0]);
      if (pending_responses.size() == 0) begin
        $error("unexpected output word %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("frame_out", want.frame_out, got.frame_out);
        check_field("show_char_valid", 11'(want.show_char_valid),
                    11'(got.show_char_valid));
        check_field("show_char", 11'(want.show_char), 11'(got.show_char));
        check_field("clear_display", 11'(want.clear_display), 11'(got.clear_display));
      end
    end
  end

  task automatic test_device_addressing();
    configure(ldtl_pkg::MODE_DEVICE, 8'ha5);
    send_frame(data_frame(8'h00));
    send_frame(11'h7ff);
    send_frame({CLASS_SKIP, 8'h00});
    send_frame(cmd_frame(ldtl_pkg::GRP_LAD, 5'd0));
    send_frame(11'h3ff);
    send_frame({ldtl_pkg::CLASS_CMD, ldtl_pkg::CMD_SDC});
    send_frame(cmd_frame(ldtl_pkg::GRP_LAD, ldtl_pkg::LOW_UNL));
    send_frame({ldtl_pkg::CLASS_CMD, ldtl_pkg::CMD_SDC});
    send_frame({ldtl_pkg::CLASS_CMD, ldtl_pkg::CMD_DCL});
    send_frame(rdy_frame(AAD_BASE | 8'd5));
    send_frame(rdy_frame(ldtl_pkg::AAD_LIMIT - 8'd1));
    send_frame(cmd_frame(ldtl_pkg::GRP_TAD, 5'd5));
    send_frame(rdy_frame(ldtl_pkg::RDY_SST));
    send_frame(rdy_frame(ldtl_pkg::RDY_SDI));
    // walk the whole ID text, then end of transmission
    repeat (ID_LEN) send_frame(any_data_frame());
    send_frame(rdy_frame(ldtl_pkg::RDY_SAI));
    send_frame(any_data_frame());
    send_frame(rdy_frame(ldtl_pkg::RDY_NRD));
    send_frame(cmd_frame(ldtl_pkg::GRP_LAD, ldtl_pkg::LOW_UNL));
    send_frame(cmd_frame(ldtl_pkg::GRP_LAD, 5'd5));
    send_frame(cmd_frame(ldtl_pkg::GRP_TAD, 5'd6));
    send_frame({ldtl_pkg::CLASS_CMD, 8'hff});
    send_frame(cmd_frame(ldtl_pkg::GRP_MISC, ldtl_pkg::LOW_AAU));
    send_frame(cmd_frame(ldtl_pkg::GRP_MISC, ldtl_pkg::LOW_IFC));
    send_frame(rdy_frame(ldtl_pkg::AAD_LIMIT));
    send_frame(rdy_frame(8'hff));
    settle();
  endtask

  task automatic test_listen_only();
    configure(ldtl_pkg::MODE_LISTEN_ONLY, 8'h00);
    send_frame(data_frame(ldtl_pkg::CHAR_LF));
    send_frame({3'd1, ldtl_pkg::CHAR_CR});
    send_frame({3'd1, 8'h1f});
    send_frame({3'd2, ldtl_pkg::CHAR_SP});
    send_frame({3'd3, LAST_PRINTABLE});
    send_frame({3'd3, 8'h80});
    send_frame(cmd_frame(ldtl_pkg::GRP_LAD, ldtl_pkg::AUTO_ADDRESS));
    settle();
  endtask

  task automatic test_scope();
    configure(ldtl_pkg::MODE_SCOPE, 8'hff);
    send_frame(data_frame(8'h41));
    send_frame(rdy_frame(ldtl_pkg::RDY_SST));
    send_frame({ldtl_pkg::CLASS_CMD, ldtl_pkg::CMD_DCL});
    settle();
  endtask

  task automatic talker_session();
    int n;
    if (!dev_assigned || $urandom_range(0, 3) == 0) begin
      send_frame(cmd_frame(ldtl_pkg::GRP_MISC, ldtl_pkg::LOW_AAU));
      send_frame(rdy_frame(AAD_BASE + 8'($urandom_range(0, AAD_SPAN))));
    end
    send_frame(cmd_frame(ldtl_pkg::GRP_TAD, dev_addr));
    case ($urandom_range(0, 3))
      0: send_frame(rdy_frame(ldtl_pkg::RDY_SST));
      1: send_frame(rdy_frame(ldtl_pkg::RDY_SDI));
      2: send_frame(rdy_frame(ldtl_pkg::RDY_SAI));
      default: send_frame(rdy_frame(ldtl_pkg::RDY_NRD));
    endcase
    n = $urandom_range(0, 9);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) send_frame(rdy_frame(ldtl_pkg::RDY_NRD));
      else send_frame(any_data_frame());
    end
    case ($urandom_range(0, 2))
      0: send_frame(cmd_frame(ldtl_pkg::GRP_TAD, dev_addr + 5'd1));
      1: send_frame(cmd_frame(ldtl_pkg::GRP_LAD, ldtl_pkg::LOW_UNL));
      default: send_frame(cmd_frame(ldtl_pkg::GRP_MISC, ldtl_pkg::LOW_IFC));
    endcase
  endtask

  task automatic listener_session();
    int n;
    send_frame(cmd_frame(ldtl_pkg::GRP_LAD, dev_addr));
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) send_frame({ldtl_pkg::CLASS_CMD, ldtl_pkg::CMD_SDC});
      else send_frame(any_data_frame());
    end
    if ($urandom_range(0, 1) == 0) send_frame(cmd_frame(ldtl_pkg::GRP_LAD, ldtl_pkg::LOW_UNL));
    else send_frame(cmd_frame(ldtl_pkg::GRP_MISC, ldtl_pkg::LOW_IFC));
  endtask

  task automatic test_random_traffic();
    ldtl_pkg::mode_t modes [0:7];
    logic [7:0]      status;
    int              target;
    modes = '{ldtl_pkg::MODE_DEVICE, ldtl_pkg::MODE_DEVICE_ALT, ldtl_pkg::MODE_DEVICE,
              ldtl_pkg::MODE_LISTEN_ONLY, ldtl_pkg::MODE_DEVICE, ldtl_pkg::MODE_SCOPE,
              ldtl_pkg::MODE_DEVICE_ALT, ldtl_pkg::MODE_DEVICE};
    for (int p = 0; p < 8; p++) begin
      if (p == 0) status = 8'h00;
      else if (p == 1) status = 8'hff;
      else status = 8'($urandom_range(0, 255));
      configure(modes[p], status);
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: talker_session();
          4, 5: listener_session();
          6: send_frame({ldtl_pkg::CLASS_CMD, 8'($urandom_range(0, 255))});
          7: send_frame({ldtl_pkg::CLASS_RDY, 8'($urandom_range(0, 255))});
          8: send_frame(11'($urandom_range(0, 2047)));
          default: send_frame(any_data_frame());
        endcase
      end
      settle();
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= ldtl_pkg::CFG_MONITOR_MODE;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_device_addressing();
    test_listen_only();
    test_scope();
    test_random_traffic();
    settle();
    if (fail_count == 0)
      $display("loop_display_talker_listener_test: PASS");
    else
      $display("loop_display_talker_listener_test: FAIL");
    $finish;
  end

endmodule

// File: sim.f
hdl/ldtl_pkg.sv
hdl/ldtl_frame_logic.sv
hdl/loop_display_talker_listener.sv
test/loop_display_talker_listener_test.sv
